FILE: src/spc_pkg.sv
// Shared types, widths and helpers for the shape pair collision test.
// Used by the square-root and divider cells and by the top level.
package spc_pkg;

    // Coordinate width taken from each input port, and port widths.
    localparam int CW     = 32;
    localparam int IW     = 32;
    localparam int OW     = 16;
    localparam int NFB    = 14;

    // Offset vector width and squared-compare operand width.
    localparam int VW     = CW + 2;
    localparam int SQ_W   = CW + 2;
    localparam int SQ_LO  = (SQ_W + 1) / 2;
    localparam int SQ_HI  = SQ_W - SQ_LO;
    localparam int PW     = $clog2(VW);

    // Normalized magnitude width, root width and divider widths.
    localparam int MW     = 31;
    localparam int RW     = MW + 1;
    localparam int RAD_W  = 2 * RW;
    localparam int QB     = NFB + 1;
    localparam int NUM_W  = MW + NFB + 1;

    typedef enum logic [1:0] {
        OP_RR = 2'd0,
        OP_CC = 2'd1,
        OP_RC = 2'd2,
        OP_CR = 2'd3
    } t_op;

    // Payload of one square-root cell.
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic              zero;
        logic              sx;
        logic              sy;
        logic [MW-1:0]     mx;
        logic [MW-1:0]     my;
        logic [RAD_W-1:0]  rad;
        logic [RW+1:0]     rem;
        logic [RW-1:0]     root;
    } t_sq;

    // Payload of one divider cell; both components share the divisor.
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic              zero;
        logic              sx;
        logic              sy;
        logic [RW-1:0]     len;
        logic [QB-1:0]     nbx;
        logic [QB-1:0]     nby;
        logic [RW-1:0]     remx;
        logic [RW-1:0]     remy;
        logic [QB-1:0]     qx;
        logic [QB-1:0]     qy;
    } t_dv;

    // Position of the highest set bit, zero for an all-zero word.
    function automatic logic [PW-1:0] lead_one(input logic [VW-1:0] v);
        logic [PW-1:0] p;
        p = '0;
        for (int i = 0; i < VW; i++) begin
            if (v[i]) begin
                p = PW'(i);
            end
        end
        return p;
    endfunction

endpackage

FILE: src/spc_sqrt_cell.sv
// One restoring square-root step: retires two radicand bits, adds one root bit.
// Depends on spc_pkg for the t_sq payload.
module spc_sqrt_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  spc_pkg::t_sq i_d,
    output spc_pkg::t_sq o_q
);
    import spc_pkg::*;

    logic [RW+3:0] w_cat;
    logic [RW+3:0] w_trial;
    logic [RW+3:0] w_diff;
    logic          w_ge;
    t_sq           n_q;
    t_sq           r_q;
    logic          r_valid;

    always_comb begin
        n_q     = i_d;
        w_cat   = {i_d.rem, i_d.rad[RAD_W-1 -: 2]};
        w_trial = {2'b00, i_d.root, 2'b01};
        w_ge    = (w_cat >= w_trial);
        w_diff  = w_cat - w_trial;
        n_q.rem  = w_ge ? w_diff[RW+1:0] : w_cat[RW+1:0];
        n_q.root = {i_d.root[RW-2:0], w_ge};
        n_q.rad  = i_d.rad << 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_comb begin
        o_q       = r_q;
        o_q.valid = r_valid;
    end

endmodule

FILE: src/spc_div_cell.sv
// One restoring division step for both normal components: one quotient bit each.
// Depends on spc_pkg for the t_dv payload.
module spc_div_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  spc_pkg::t_dv i_d,
    output spc_pkg::t_dv o_q
);
    import spc_pkg::*;

    logic [RW:0] w_catx;
    logic [RW:0] w_caty;
    logic [RW:0] w_difx;
    logic [RW:0] w_dify;
    logic        w_gex;
    logic        w_gey;
    t_dv         n_q;
    t_dv         r_q;
    logic        r_valid;

    always_comb begin
        n_q    = i_d;
        w_catx = {i_d.remx, i_d.nbx[QB-1]};
        w_caty = {i_d.remy, i_d.nby[QB-1]};
        w_gex  = (w_catx >= {1'b0, i_d.len});
        w_gey  = (w_caty >= {1'b0, i_d.len});
        w_difx = w_catx - {1'b0, i_d.len};
        w_dify = w_caty - {1'b0, i_d.len};
        n_q.remx = w_gex ? w_difx[RW-1:0] : w_catx[RW-1:0];
        n_q.remy = w_gey ? w_dify[RW-1:0] : w_caty[RW-1:0];
        n_q.qx   = {i_d.qx[QB-2:0], w_gex};
        n_q.qy   = {i_d.qy[QB-2:0], w_gey};
        n_q.nbx  = i_d.nbx << 1;
        n_q.nby  = i_d.nby << 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_comb begin
        o_q       = r_q;
        o_q.valid = r_valid;
    end

endmodule

FILE: src/shape_pair_collision_test.sv
// Narrow-phase collision test for a pair of rectangles or circles.
// Depends on spc_pkg, spc_sqrt_cell and spc_div_cell.
//
// Throughput is one pair per cycle; busy is never raised, since every stage moves each cycle.
// A pair passes the front stages, the 32-cell square-root chain, the divider setup register,
// the 15-cell divider chain and the output register before the result strobe o_valid.
// Reset (synchronous, active low) clears all valid bits; no result is in flight after it.
module shape_pair_collision_test (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_op,
    input  logic [spc_pkg::IW-1:0]   i_a_x_first,
    input  logic [spc_pkg::IW-1:0]   i_a_y_first,
    input  logic [spc_pkg::IW-1:0]   i_a_x_second,
    input  logic [spc_pkg::IW-1:0]   i_a_y_second,
    input  logic [spc_pkg::IW-1:0]   i_b_x_first,
    input  logic [spc_pkg::IW-1:0]   i_b_y_first,
    input  logic [spc_pkg::IW-1:0]   i_b_x_second,
    input  logic [spc_pkg::IW-1:0]   i_b_y_second,
    output logic                     o_valid,
    output logic                     o_hit,
    output logic [spc_pkg::OW-1:0]   o_normal_x,
    output logic [spc_pkg::OW-1:0]   o_normal_y
);
    import spc_pkg::*;

    localparam int LAT = 9 + RW + 1 + QB + 1;

    // The pipeline never stalls, so a transfer is taken on every start.
    logic w_accept;
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Valid bits of the front stages one through nine.
    logic [9:1] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[8:1], w_accept};
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: sign-extend, pick rectangle and circle roles, form the
    // offset vector and the rect-circle sums and face flags.
    // ---------------------------------------------------------------
    t_op                   w_op;
    logic signed [CW-1:0]  ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic signed [CW-1:0]  rx1, ry1, rx2, ry2, px, py, pr;
    logic                  n1_rrhit;
    logic signed [CW:0]    n1_vxcc, n1_vycc, n1_sum, n1_w, n1_h, n1_r2;
    logic signed [VW-1:0]  n1_ox, n1_oy, n1_vx, n1_vy;

    logic                  r1_rrhit;
    t_op                   r1_op;
    logic signed [CW:0]    r1_vxcc, r1_vycc, r1_sum, r1_w, r1_h, r1_r2;
    logic signed [VW-1:0]  r1_ox, r1_oy, r1_vx, r1_vy;

    always_comb begin
        w_op = t_op'(i_op);
        ax1 = i_a_x_first[CW-1:0];
        ay1 = i_a_y_first[CW-1:0];
        ax2 = i_a_x_second[CW-1:0];
        ay2 = i_a_y_second[CW-1:0];
        bx1 = i_b_x_first[CW-1:0];
        by1 = i_b_y_first[CW-1:0];
        bx2 = i_b_x_second[CW-1:0];
        by2 = i_b_y_second[CW-1:0];

        // Circle-rectangle swaps the roles so one datapath serves both orders.
        if (w_op == OP_CR) begin
            rx1 = bx1; ry1 = by1; rx2 = bx2; ry2 = by2;
            px  = ax1; py  = ay1; pr  = ax2;
        end else begin
            rx1 = ax1; ry1 = ay1; rx2 = ax2; ry2 = ay2;
            px  = bx1; py  = by1; pr  = bx2;
        end

        n1_rrhit = (ax1 <= bx2) && (ax2 >= bx1) && (ay2 <= by1) && (ay1 >= by2);
        n1_vxcc  = (CW+1)'(bx1) - (CW+1)'(ax1);
        n1_vycc  = (CW+1)'(by1) - (CW+1)'(ay1);
        n1_sum   = (CW+1)'(ax2) + (CW+1)'(bx2);
        n1_w     = (CW+1)'(rx2) - (CW+1)'(rx1);
        n1_h     = (CW+1)'(ry1) - (CW+1)'(ry2);
        n1_r2    = (CW+1)'(pr) <<< 1;
        n1_ox    = (VW'(px) <<< 1) - VW'(rx1) - VW'(rx2);
        n1_oy    = (VW'(py) <<< 1) - VW'(ry1) - VW'(ry2);

        // The offset vector is fixed here; it only matters if the pair hits.
        unique case (w_op) inside
            OP_RR: begin
                n1_vx = VW'(bx1) + VW'(bx2) - VW'(ax1) - VW'(ax2);
                n1_vy = VW'(by1) + VW'(by2) - VW'(ay1) - VW'(ay2);
            end
            OP_CC: begin
                n1_vx = VW'(n1_vxcc);
                n1_vy = VW'(n1_vycc);
            end
            OP_RC, OP_CR: begin
                // Face normal when the center is beyond a face, else center offset.
                if (py > ry1) begin
                    n1_vx = '0;
                    n1_vy = VW'(1);
                end else if (py < ry2) begin
                    n1_vx = '0;
                    n1_vy = -VW'(1);
                end else if (px < rx1) begin
                    n1_vx = -VW'(1);
                    n1_vy = '0;
                end else if (px > rx2) begin
                    n1_vx = VW'(1);
                    n1_vy = '0;
                end else begin
                    n1_vx = n1_ox;
                    n1_vy = n1_oy;
                end
            end
            default: begin
                n1_vx = '0;
                n1_vy = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r1_op    <= w_op;
        r1_rrhit <= n1_rrhit;
        r1_vxcc  <= n1_vxcc;
        r1_vycc  <= n1_vycc;
        r1_sum   <= n1_sum;
        r1_w     <= n1_w;
        r1_h     <= n1_h;
        r1_r2    <= n1_r2;
        r1_ox    <= n1_ox;
        r1_oy    <= n1_oy;
        r1_vx    <= n1_vx;
        r1_vy    <= n1_vy;
    end

    // ---------------------------------------------------------------
    // Stage 2: box tests for rect-circle and selection of the operands
    // of the exact squared-distance compare.
    // ---------------------------------------------------------------
    logic [VW-1:0]         w_dx, w_dy;
    logic signed [VW:0]    w_sdx, w_sdy, w_wr, w_hr, w_ex, w_ey;
    logic                  w_far, w_corner;
    logic [SQ_W-1:0]       n2_p, n2_q, n2_t;
    logic                  n2_force, n2_need;

    logic [SQ_W-1:0]       r2_p, r2_q, r2_t;
    logic                  r2_force, r2_need;
    logic signed [VW-1:0]  r2_vx, r2_vy;

    always_comb begin
        w_dx  = r1_ox[VW-1] ? VW'(-r1_ox) : VW'(r1_ox);
        w_dy  = r1_oy[VW-1] ? VW'(-r1_oy) : VW'(r1_oy);
        w_sdx = $signed({1'b0, w_dx});
        w_sdy = $signed({1'b0, w_dy});
        w_wr  = (VW+1)'(r1_w) + (VW+1)'(r1_r2);
        w_hr  = (VW+1)'(r1_h) + (VW+1)'(r1_r2);
        w_far    = (w_sdx > w_wr) || (w_sdy > w_hr);
        w_corner = (w_sdx > (VW+1)'(r1_w)) && (w_sdy > (VW+1)'(r1_h));
        w_ex  = w_sdx - (VW+1)'(r1_w);
        w_ey  = w_sdy - (VW+1)'(r1_h);

        unique case (r1_op) inside
            OP_RR: begin
                n2_p     = '0;
                n2_q     = '0;
                n2_t     = '0;
                n2_force = r1_rrhit;
                n2_need  = 1'b0;
            end
            OP_CC: begin
                n2_p     = SQ_W'(r1_vxcc[CW] ? -r1_vxcc : r1_vxcc);
                n2_q     = SQ_W'(r1_vycc[CW] ? -r1_vycc : r1_vycc);
                n2_t     = SQ_W'(r1_sum[CW]  ? -r1_sum  : r1_sum);
                n2_force = 1'b0;
                n2_need  = !r1_sum[CW];
            end
            OP_RC, OP_CR: begin
                n2_p     = w_ex[SQ_W-1:0];
                n2_q     = w_ey[SQ_W-1:0];
                n2_t     = SQ_W'(r1_r2[CW] ? -r1_r2 : r1_r2);
                n2_force = !w_far && !w_corner;
                n2_need  = !w_far && w_corner;
            end
            default: begin
                n2_p     = '0;
                n2_q     = '0;
                n2_t     = '0;
                n2_force = 1'b0;
                n2_need  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r2_p     <= n2_p;
        r2_q     <= n2_q;
        r2_t     <= n2_t;
        r2_force <= n2_force;
        r2_need  <= n2_need;
        r2_vx    <= r1_vx;
        r2_vy    <= r1_vy;
    end

    // ---------------------------------------------------------------
    // Stage 3: partial products of the three squares, split in halves.
    // ---------------------------------------------------------------
    logic [SQ_W-1:0]         w_opnd [3];
    logic [2*SQ_HI-1:0]      r3_hh  [3];
    logic [SQ_HI+SQ_LO-1:0]  r3_hl  [3];
    logic [2*SQ_LO-1:0]      r3_ll  [3];
    logic                    r3_force, r3_need;
    logic signed [VW-1:0]    r3_vx, r3_vy;

    assign w_opnd[0] = r2_p;
    assign w_opnd[1] = r2_q;
    assign w_opnd[2] = r2_t;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r3_hh[k] <= (2*SQ_HI)'(w_opnd[k][SQ_W-1:SQ_LO])
                        * (2*SQ_HI)'(w_opnd[k][SQ_W-1:SQ_LO]);
            r3_hl[k] <= (SQ_HI+SQ_LO)'(w_opnd[k][SQ_W-1:SQ_LO])
                        * (SQ_HI+SQ_LO)'(w_opnd[k][SQ_LO-1:0]);
            r3_ll[k] <= (2*SQ_LO)'(w_opnd[k][SQ_LO-1:0])
                        * (2*SQ_LO)'(w_opnd[k][SQ_LO-1:0]);
        end
        r3_force <= r2_force;
        r3_need  <= r2_need;
        r3_vx    <= r2_vx;
        r3_vy    <= r2_vy;
    end

    // ---------------------------------------------------------------
    // Stage 4: assemble the squares; the cross term counts twice.
    // ---------------------------------------------------------------
    logic [2*SQ_W-1:0]     w_sq_val [3];
    logic [2*SQ_W:0]       r4_dsum;
    logic [2*SQ_W-1:0]     r4_t2;
    logic                  r4_force, r4_need;
    logic signed [VW-1:0]  r4_vx, r4_vy;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sq_val[k] = ((2*SQ_W)'(r3_hh[k]) << (2*SQ_LO))
                        + ((2*SQ_W)'(r3_hl[k]) << (SQ_LO + 1))
                        + (2*SQ_W)'(r3_ll[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r4_dsum  <= (2*SQ_W+1)'(w_sq_val[0]) + (2*SQ_W+1)'(w_sq_val[1]);
        r4_t2    <= w_sq_val[2];
        r4_force <= r3_force;
        r4_need  <= r3_need;
        r4_vx    <= r3_vx;
        r4_vy    <= r3_vy;
    end

    // ---------------------------------------------------------------
    // Stage 5: final hit decision.
    // ---------------------------------------------------------------
    logic                  r5_hit;
    logic signed [VW-1:0]  r5_vx, r5_vy;

    always_ff @(posedge i_clk) begin
        r5_hit <= r4_force || (r4_need && (r4_dsum <= (2*SQ_W+1)'(r4_t2)));
        r5_vx  <= r4_vx;
        r5_vy  <= r4_vy;
    end

    // ---------------------------------------------------------------
    // Stage 6: magnitudes, signs and the leading-one position of the
    // larger magnitude.
    // ---------------------------------------------------------------
    logic [VW-1:0]  w_mx, w_my, w_m;
    logic [VW-1:0]  r6_mx, r6_my;
    logic [PW-1:0]  r6_lead;
    logic           r6_hit, r6_zero, r6_sx, r6_sy;

    always_comb begin
        w_mx = r5_vx[VW-1] ? VW'(-r5_vx) : VW'(r5_vx);
        w_my = r5_vy[VW-1] ? VW'(-r5_vy) : VW'(r5_vy);
        w_m  = (w_mx > w_my) ? w_mx : w_my;
    end

    always_ff @(posedge i_clk) begin
        r6_mx   <= w_mx;
        r6_my   <= w_my;
        r6_lead <= lead_one(w_m);
        r6_zero <= (w_m == '0);
        r6_hit  <= r5_hit;
        r6_sx   <= r5_vx[VW-1];
        r6_sy   <= r5_vy[VW-1];
    end

    // ---------------------------------------------------------------
    // Stage 7: shift so the larger magnitude has its top bit just
    // below bit MW; right shifts truncate.
    // ---------------------------------------------------------------
    logic           w_right;
    logic [PW-1:0]  w_amt;
    logic [VW-1:0]  w_nx, w_ny;
    logic [MW-1:0]  r7_mx, r7_my;
    logic           r7_hit, r7_zero, r7_sx, r7_sy;

    always_comb begin
        w_right = (r6_lead >= PW'(MW - 1));
        w_amt   = w_right ? (r6_lead - PW'(MW - 1)) : (PW'(MW - 1) - r6_lead);
        w_nx    = w_right ? (r6_mx >> w_amt) : (r6_mx << w_amt);
        w_ny    = w_right ? (r6_my >> w_amt) : (r6_my << w_amt);
    end

    always_ff @(posedge i_clk) begin
        r7_mx   <= w_nx[MW-1:0];
        r7_my   <= w_ny[MW-1:0];
        r7_hit  <= r6_hit;
        r7_zero <= r6_zero;
        r7_sx   <= r6_sx;
        r7_sy   <= r6_sy;
    end

    // ---------------------------------------------------------------
    // Stages 8 and 9: squared length of the normalized vector.
    // ---------------------------------------------------------------
    logic [2*MW-1:0]  r8_sqx, r8_sqy;
    logic [MW-1:0]    r8_mx, r8_my;
    logic             r8_hit, r8_zero, r8_sx, r8_sy;
    logic [2*MW:0]    r9_sum;
    logic [MW-1:0]    r9_mx, r9_my;
    logic             r9_hit, r9_zero, r9_sx, r9_sy;

    always_ff @(posedge i_clk) begin
        r8_sqx  <= (2*MW)'(r7_mx) * (2*MW)'(r7_mx);
        r8_sqy  <= (2*MW)'(r7_my) * (2*MW)'(r7_my);
        r8_mx   <= r7_mx;
        r8_my   <= r7_my;
        r8_hit  <= r7_hit;
        r8_zero <= r7_zero;
        r8_sx   <= r7_sx;
        r8_sy   <= r7_sy;

        r9_sum  <= (2*MW+1)'(r8_sqx) + (2*MW+1)'(r8_sqy);
        r9_mx   <= r8_mx;
        r9_my   <= r8_my;
        r9_hit  <= r8_hit;
        r9_zero <= r8_zero;
        r9_sx   <= r8_sx;
        r9_sy   <= r8_sy;
    end

    // ---------------------------------------------------------------
    // Square-root chain: one cell per root bit.
    // ---------------------------------------------------------------
    t_sq w_sq [RW+1];

    always_comb begin
        w_sq[0].valid = r_vld[9];
        w_sq[0].hit   = r9_hit;
        w_sq[0].zero  = r9_zero;
        w_sq[0].sx    = r9_sx;
        w_sq[0].sy    = r9_sy;
        w_sq[0].mx    = r9_mx;
        w_sq[0].my    = r9_my;
        w_sq[0].rad   = RAD_W'(r9_sum);
        w_sq[0].rem   = '0;
        w_sq[0].root  = '0;
    end

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        spc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_sq[g]),
            .o_q     (w_sq[g+1])
        );
    end

    // ---------------------------------------------------------------
    // Divider setup: numerator is m * 2^NFB plus half the length, so
    // the quotient comes out rounded. The quotient never exceeds
    // 2^NFB, so the top bits of the numerator start as the remainder.
    // ---------------------------------------------------------------
    logic [NUM_W-1:0] w_numx, w_numy;
    t_dv              n_dv0;
    t_dv              r_dv0;
    logic             r_dv0_valid;
    t_dv              w_dv [QB+1];

    always_comb begin
        w_numx = (NUM_W'(w_sq[RW].mx) << NFB) + NUM_W'(w_sq[RW].root >> 1);
        w_numy = (NUM_W'(w_sq[RW].my) << NFB) + NUM_W'(w_sq[RW].root >> 1);
        n_dv0.valid = w_sq[RW].valid;
        n_dv0.hit   = w_sq[RW].hit;
        n_dv0.zero  = w_sq[RW].zero;
        n_dv0.sx    = w_sq[RW].sx;
        n_dv0.sy    = w_sq[RW].sy;
        n_dv0.len   = w_sq[RW].root;
        n_dv0.nbx   = w_numx[QB-1:0];
        n_dv0.nby   = w_numy[QB-1:0];
        n_dv0.remx  = RW'(w_numx[NUM_W-1:QB]);
        n_dv0.remy  = RW'(w_numy[NUM_W-1:QB]);
        n_dv0.qx    = '0;
        n_dv0.qy    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv0_valid <= 1'b0;
        end else begin
            r_dv0_valid <= w_sq[RW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv0 <= n_dv0;
    end

    always_comb begin
        w_dv[0]       = r_dv0;
        w_dv[0].valid = r_dv0_valid;
    end

    for (genvar g = 0; g < QB; g++) begin : g_div
        spc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_dv[g]),
            .o_q     (w_dv[g+1])
        );
    end

    // ---------------------------------------------------------------
    // Output register: apply the signs; a miss or a zero-length offset
    // gives a zero normal. The result is shown for exactly one cycle.
    // ---------------------------------------------------------------
    logic [OW-1:0] w_qx, w_qy;
    logic [OW-1:0] n_nx, n_ny;
    logic          w_keep;
    logic          r_out_valid;
    logic          r_out_hit;
    logic [OW-1:0] r_out_nx, r_out_ny;

    always_comb begin
        w_qx   = OW'(w_dv[QB].qx);
        w_qy   = OW'(w_dv[QB].qy);
        w_keep = w_dv[QB].hit && !w_dv[QB].zero;
        n_nx   = !w_keep ? '0 : (w_dv[QB].sx ? -w_qx : w_qx);
        n_ny   = !w_keep ? '0 : (w_dv[QB].sy ? -w_qy : w_qy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_dv[QB].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hit <= w_dv[QB].hit;
        r_out_nx  <= n_nx;
        r_out_ny  <= n_ny;
    end

    assign o_valid    = r_out_valid;
    assign o_hit      = r_out_hit;
    assign o_normal_x = r_out_nx;
    assign o_normal_y = r_out_ny;

`ifndef SYNTHESIS
    // Every accepted pair leaves the pipeline with a result strobe on o_valid.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_valid)
        else $error("result strobe missing after a start transfer");

    // A miss always reports a zero normal.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_normal_x == '0 && o_normal_y == '0))
        else $error("nonzero normal on a miss");

    // After normalization the length always has one of its top two bits set.
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sq[RW].valid && w_sq[RW].hit && !w_sq[RW].zero)
        |-> (w_sq[RW].root[RW-1:RW-2] != 2'b00))
        else $error("square root out of the normalized range");

    // A unit normal component never exceeds one in the output format.
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dv[QB].valid && w_dv[QB].hit && !w_dv[QB].zero)
        |-> (w_dv[QB].qx <= (QB'(1) << NFB) && w_dv[QB].qy <= (QB'(1) << NFB)))
        else $error("normal component above one");
`endif

endmodule
